>>> src/scrd_pkg.sv
// ----------------------------------------------------------------------------
// scrd_pkg
// Types, codes and constant tables of the Super I/O configuration decoder.
// ----------------------------------------------------------------------------
package scrd_pkg;

	// access codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_SRST  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FER = 2'd0;
	localparam logic [1:0] REG_FAR = 2'd1;
	localparam logic [1:0] REG_PTR = 2'd2;
	localparam int unsigned NUM_REGS = 3;

	// index-port read sequence
	localparam logic [1:0] STEP_ID   = 2'd0;
	localparam logic [1:0] STEP_ZERO = 2'd1;
	localparam logic [1:0] STEP_IDX  = 2'd2;

	localparam logic [7:0] ID_BYTE       = 8'h88;
	localparam logic [4:0] STRAP_DEFAULT = 5'd1;
	localparam int unsigned STRAP_ROWS   = 32;

	localparam logic [9:0] COM1_BASE     = 10'h3f8;
	localparam logic [9:0] COM2_BASE     = 10'h2f8;
	localparam logic [9:0] FDC_PRI_BASE  = 10'h3f0;
	localparam logic [9:0] FDC_SEC_BASE  = 10'h370;
	localparam logic [9:0] IDE_PRI_BASE  = 10'h1f0;
	localparam logic [9:0] IDE_SEC_BASE  = 10'h170;
	localparam logic [9:0] IDE_CTRL_OFS  = 10'h206;
	localparam logic [9:0] LPT_BASE_0    = 10'h378;
	localparam logic [9:0] LPT_BASE_1    = 10'h3bc;
	localparam logic [9:0] LPT_BASE_2    = 10'h278;

	localparam logic [7:0] FER_ROWS [STRAP_ROWS] = '{
		8'h4f, 8'h4f, 8'h4f, 8'h4f, 8'h4f, 8'h4f, 8'h4b, 8'h4b,
		8'h4b, 8'h4b, 8'h4b, 8'h4b, 8'h0f, 8'h0f, 8'h0f, 8'h0f,
		8'h49, 8'h49, 8'h49, 8'h49, 8'h07, 8'h07, 8'h07, 8'h07,
		8'h47, 8'h47, 8'h47, 8'h47, 8'h47, 8'h47, 8'h08, 8'h00
	};
	localparam logic [7:0] FAR_ROWS [STRAP_ROWS] = '{
		8'h10, 8'h11, 8'h11, 8'h39, 8'h24, 8'h38, 8'h00, 8'h01,
		8'h01, 8'h09, 8'h08, 8'h08, 8'h10, 8'h11, 8'h39, 8'h24,
		8'h00, 8'h01, 8'h01, 8'h00, 8'h10, 8'h11, 8'h39, 8'h24,
		8'h10, 8'h11, 8'h11, 8'h39, 8'h24, 8'h38, 8'h10, 8'h10
	};
	// power/test reset value is zero except on the last strap row
	localparam logic [7:0] PTR_LAST = 8'h02;

	typedef struct packed {
		logic [1:0] func;
		logic       data_port;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [4:0] device_enables;
		logic [9:0] lpt_base;
		logic [3:0] lpt_irq;
		logic [9:0] uart_one_base;
		logic [3:0] uart_one_irq;
		logic [9:0] uart_two_base;
		logic [3:0] uart_two_irq;
		logic [9:0] floppy_base;
		logic [9:0] ide_base;
		logic [9:0] ide_control_base;
	} rsp_t;

	// UART base from its 2-bit select and the shared alternate-set field
	function automatic logic [9:0] com_base(input logic [1:0] sel, input logic [1:0] alt);
		logic [9:0] base;
		base = COM1_BASE;
		case (sel)
			2'd0: base = COM1_BASE;
			2'd1: base = COM2_BASE;
			2'd2: begin
				case (alt)
					2'd0:    base = 10'h3e8;
					2'd1:    base = 10'h338;
					2'd2:    base = 10'h2e8;
					default: base = 10'h220;
				endcase
			end
			default: begin
				case (alt)
					2'd0:    base = 10'h2e8;
					2'd1:    base = 10'h238;
					2'd2:    base = 10'h2e0;
					default: base = 10'h228;
				endcase
			end
		endcase
		return base;
	endfunction

endpackage

>>> src/scrd_ifs.sv
// ----------------------------------------------------------------------------
// scrd_ifs
// Valid/ready channels of the Super I/O configuration decoder.
// ----------------------------------------------------------------------------
interface scrd_req_if;
	logic            valid;
	logic            ready;
	scrd_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scrd_rsp_if;
	logic            valid;
	logic            ready;
	scrd_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scrd_cfg_if;
	logic        valid;
	logic        ready;
	logic [4:0]  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/superio_config_register_decoder.sv
// ----------------------------------------------------------------------------
// superio_config_register_decoder
// Index/data configuration port of a Super I/O block with resource decode.
// ----------------------------------------------------------------------------
// Accepted accesses pass through the input register, one decode pass and the
// result register; one access per cycle while the result side is not stalled,
// with the result register freed in the same cycle it is taken.
// Reset (arst_n low): registers load strap row 1 (0x4f, 0x11, 0x00), index
// and ID step clear, strap setting returns to 1, both stages empty.
module superio_config_register_decoder (
	input  logic        clk,
	input  logic        arst_n,
	scrd_cfg_if.sink    cfg,
	scrd_req_if.sink    req,
	scrd_rsp_if.source  rsp
);
	import scrd_pkg::*;

	logic       req_valid_s1;
	req_t       req_s1;
	logic       rsp_valid_s2;
	rsp_t       rsp_s2;
	logic       advance;

	logic [4:0] strap_q;
	logic [7:0] regs_q [NUM_REGS];
	logic [7:0] sel_q;
	logic [1:0] step_q;

	logic [7:0] regs_d [NUM_REGS];
	logic [7:0] sel_d;
	logic [1:0] step_d;
	logic [7:0] rdata;
	rsp_t       rsp_d;

	assign cfg.ready = 1'b1;
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;
	assign rsp.valid = rsp_valid_s2;
	assign rsp.data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strap_q <= STRAP_DEFAULT;
		end else if (cfg.valid) begin
			strap_q <= cfg.data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// register update
	always_comb begin
		regs_d = regs_q;
		sel_d  = sel_q;
		step_d = step_q;
		rdata  = 8'h00;
		case (req_s1.func)
			FUNC_READ: begin
				if (!req_s1.data_port) begin
					case (step_q)
						STEP_ID: begin
							rdata  = ID_BYTE;
							step_d = STEP_ZERO;
						end
						STEP_ZERO: begin
							rdata  = 8'h00;
							step_d = STEP_IDX;
						end
						default: begin
							rdata  = sel_q;
							step_d = STEP_IDX;
						end
					endcase
				end else if (sel_q < 8'(NUM_REGS)) begin
					rdata = regs_q[sel_q[1:0]];
				end
			end
			FUNC_WRITE: begin
				if (!req_s1.data_port) begin
					step_d = STEP_IDX;
					sel_d  = req_s1.write_data;
				end else if (sel_q < 8'(NUM_REGS)) begin
					regs_d[sel_q[1:0]] = req_s1.write_data;
				end
			end
			FUNC_SRST: begin
				step_d       = STEP_ID;
				sel_d        = 8'h00;
				regs_d[REG_FER] = FER_ROWS[strap_q];
				regs_d[REG_FAR] = FAR_ROWS[strap_q];
				regs_d[REG_PTR] = (strap_q == 5'(STRAP_ROWS - 1)) ? PTR_LAST : 8'h00;
			end
			default: begin
				rdata = 8'h00;
			end
		endcase
	end

	// resource decode from the updated registers
	always_comb begin
		logic [7:0] fer;
		logic [7:0] far;
		fer = regs_d[REG_FER];
		far = regs_d[REG_FAR];
		rsp_d.read_data      = rdata;
		rsp_d.device_enables = {fer[6], fer[3:0]};
		case (far[1:0])
			2'd0: begin
				rsp_d.lpt_base = LPT_BASE_0;
				rsp_d.lpt_irq  = regs_d[REG_PTR][3] ? 4'd7 : 4'd5;
			end
			2'd1: begin
				rsp_d.lpt_base = LPT_BASE_1;
				rsp_d.lpt_irq  = 4'd7;
			end
			2'd2: begin
				rsp_d.lpt_base = LPT_BASE_2;
				rsp_d.lpt_irq  = 4'd5;
			end
			default: begin
				rsp_d.lpt_base = 10'h000;
				rsp_d.lpt_irq  = 4'd0;
			end
		endcase
		rsp_d.uart_one_base    = com_base(far[3:2], far[7:6]);
		rsp_d.uart_one_irq     = far[2] ? 4'd3 : 4'd4;
		rsp_d.uart_two_base    = com_base(far[5:4], far[7:6]);
		rsp_d.uart_two_irq     = far[4] ? 4'd3 : 4'd4;
		rsp_d.floppy_base      = fer[5] ? FDC_SEC_BASE : FDC_PRI_BASE;
		rsp_d.ide_base         = fer[7] ? IDE_SEC_BASE : IDE_PRI_BASE;
		rsp_d.ide_control_base = rsp_d.ide_base + IDE_CTRL_OFS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_FER] <= FER_ROWS[STRAP_DEFAULT];
			regs_q[REG_FAR] <= FAR_ROWS[STRAP_DEFAULT];
			regs_q[REG_PTR] <= 8'h00;
			sel_q           <= 8'h00;
			step_q          <= STEP_ID;
		end else if (advance) begin
			regs_q <= regs_d;
			sel_q  <= sel_d;
			step_q <= step_d;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Super I/O configuration register decoder.
// Accesses go in on the request channel. A predictor tracks the registers,
// the selected index, the ID read step and the strap row, and it queues the
// expected decode. Each result beat is checked field by field against that
// queue. Both channels get random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scrd_pkg::*;

	localparam logic [1:0] FUNC_NONE       = 2'd3;
	localparam int         IDLE_LIMIT      = 2000;
	localparam int         RANDOM_ACCESSES = 1400;
	localparam int         SETTLE_CYCLES   = 4;
	localparam int         REPORT_MAX      = 10;

	localparam logic [9:0] LPT_NONE = 10'h000;
	localparam logic [3:0] IRQ_NONE = 4'd0;
	localparam logic [3:0] IRQ3     = 4'd3;
	localparam logic [3:0] IRQ4     = 4'd4;
	localparam logic [3:0] IRQ5     = 4'd5;
	localparam logic [3:0] IRQ7     = 4'd7;

	// alternate UART bases, by low select bit and the shared alternate-set field
	localparam logic [9:0] UART_ALT_BASES [2][4] = '{
		'{10'h3e8, 10'h338, 10'h2e8, 10'h220},
		'{10'h2e8, 10'h238, 10'h2e0, 10'h228}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	scrd_cfg_if cfg();
	scrd_req_if req();
	scrd_rsp_if rsp();

	superio_config_register_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	always #5ns clk = ~clk;

	// predictor state
	logic [7:0] reg_file [NUM_REGS];
	logic [7:0] index_sel;
	logic [1:0] id_step;
	logic [4:0] strap_row;

	rsp_t pending_decodes [$];
	int   mismatches    = 0;
	int   accesses_sent = 0;
	int   idle_cycles   = 0;
	bit   quiet         = 1'b0;

	function automatic void load_strap_row();
		id_step             = STEP_ID;
		index_sel           = '0;
		reg_file[REG_FER]   = FER_ROWS[strap_row];
		reg_file[REG_FAR]   = FAR_ROWS[strap_row];
		reg_file[REG_PTR]   = (strap_row == STRAP_ROWS - 1) ? PTR_LAST : 8'h00;
	endfunction

	function automatic logic [9:0] predict_com_base(input logic [1:0] sel,
		input logic [1:0] alt);
		case (sel)
			2'd0:    return COM1_BASE;
			2'd1:    return COM2_BASE;
			default: return UART_ALT_BASES[sel[0]][alt];
		endcase
	endfunction

	// apply one access to the predicted state and return the decode it causes
	function automatic rsp_t decode_access(input req_t a);
		rsp_t       r;
		logic [7:0] fer;
		logic [7:0] far;
		logic [9:0] ide;
		r = '0;
		case (a.func)
			FUNC_READ: begin
				if (!a.data_port) begin
					case (id_step)
						STEP_ID: begin
							r.read_data = ID_BYTE;
							id_step     = STEP_ZERO;
						end
						STEP_ZERO: begin
							r.read_data = 8'h00;
							id_step     = STEP_IDX;
						end
						default: begin
							r.read_data = index_sel;
							id_step     = STEP_IDX;
						end
					endcase
				end else if (index_sel < NUM_REGS) begin
					r.read_data = reg_file[index_sel[1:0]];
				end
			end
			FUNC_WRITE: begin
				if (!a.data_port) begin
					id_step   = STEP_IDX;
					index_sel = a.write_data;
				end else if (index_sel < NUM_REGS) begin
					reg_file[index_sel[1:0]] = a.write_data;
				end
			end
			FUNC_SRST: begin
				load_strap_row();
			end
			default: begin
			end
		endcase

		fer = reg_file[REG_FER];
		far = reg_file[REG_FAR];
		r.device_enables = {fer[6], fer[3:0]};
		case (far[1:0])
			2'd0: begin
				r.lpt_base = LPT_BASE_0;
				r.lpt_irq  = reg_file[REG_PTR][3] ? IRQ7 : IRQ5;
			end
			2'd1: begin
				r.lpt_base = LPT_BASE_1;
				r.lpt_irq  = IRQ7;
			end
			2'd2: begin
				r.lpt_base = LPT_BASE_2;
				r.lpt_irq  = IRQ5;
			end
			default: begin
				r.lpt_base = LPT_NONE;
				r.lpt_irq  = IRQ_NONE;
			end
		endcase
		r.uart_one_base    = predict_com_base(far[3:2], far[7:6]);
		r.uart_one_irq     = far[2] ? IRQ3 : IRQ4;
		r.uart_two_base    = predict_com_base(far[5:4], far[7:6]);
		r.uart_two_irq     = far[4] ? IRQ3 : IRQ4;
		r.floppy_base      = fer[5] ? FDC_SEC_BASE : FDC_PRI_BASE;
		ide                = fer[7] ? IDE_SEC_BASE : IDE_PRI_BASE;
		r.ide_base         = ide;
		r.ide_control_base = ide + IDE_CTRL_OFS;
		return r;
	endfunction

	// mostly short gaps, a few long ones, none in quiet stretches
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(input string name, input logic [9:0] want,
		input logic [9:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch in %s: expected 0x%0h, got 0x%0h at %0t",
					name, want, got, $time);
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_decodes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result beat %p at %0t", rsp.data, $time);
			end else begin
				want = pending_decodes.pop_front();
				check_field("read_data", 10'(want.read_data),
					10'(rsp.data.read_data));
				check_field("device_enables", 10'(want.device_enables),
					10'(rsp.data.device_enables));
				check_field("lpt_base",         want.lpt_base,         rsp.data.lpt_base);
				check_field("lpt_irq", 10'(want.lpt_irq), 10'(rsp.data.lpt_irq));
				check_field("uart_one_base",    want.uart_one_base,    rsp.data.uart_one_base);
				check_field("uart_one_irq", 10'(want.uart_one_irq),
					10'(rsp.data.uart_one_irq));
				check_field("uart_two_base",    want.uart_two_base,    rsp.data.uart_two_base);
				check_field("uart_two_irq", 10'(want.uart_two_irq),
					10'(rsp.data.uart_two_irq));
				check_field("floppy_base",      want.floppy_base,      rsp.data.floppy_base);
				check_field("ide_base",         want.ide_base,         rsp.data.ide_base);
				check_field("ide_control_base", want.ide_control_base, rsp.data.ide_control_base);
			end
		end
	end

	// watchdog: count cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb NOT OK");
		$finish;
	end

	// result side: random stalls between runs of ready
	initial begin
		int stall;
		int hold;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			hold = $urandom_range(1, 12);
			repeat (hold) @(posedge clk);
		end
	end

	task automatic send_access(input logic [1:0] f, input logic dp, input logic [7:0] wd);
		int   gap;
		req_t item;
		item.func       = f;
		item.data_port  = dp;
		item.write_data = wd;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// keep valid high across back-to-back beats
		req.valid <= 1'b1;
		req.data  <= item;
		do @(posedge clk); while (!req.ready);
		pending_decodes.push_back(decode_access(item));
		if (f != FUNC_NONE)
			accesses_sent++;
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_strap(input logic [4:0] row);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.data  <= row;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		strap_row = row;
	endtask

	task automatic test_id_sequence();
		send_access(FUNC_READ, 1'b0, 8'h00);
		send_access(FUNC_READ, 1'b0, 8'hff);
		send_access(FUNC_READ, 1'b0, 8'h00);
		// step holds at the index once the sequence is done
		send_access(FUNC_READ, 1'b0, 8'h00);
		send_access(FUNC_READ, 1'b1, 8'h00);
		// index past the last register: data side reads zero, drops writes
		send_access(FUNC_WRITE, 1'b0, 8'hff);
		send_access(FUNC_WRITE, 1'b1, 8'h5a);
		send_access(FUNC_READ, 1'b1, 8'h00);
		send_access(FUNC_READ, 1'b0, 8'h00);
		send_access(FUNC_NONE, 1'b1, 8'hff);
	endtask

	task automatic test_register_access();
		for (int r = 0; r < NUM_REGS; r++) begin
			send_access(FUNC_WRITE, 1'b0, 8'(r));
			send_access(FUNC_WRITE, 1'b1, 8'hff);
			send_access(FUNC_READ, 1'b1, 8'h00);
			send_access(FUNC_WRITE, 1'b1, 8'h00);
		end
		send_access(FUNC_SRST, 1'b0, 8'h00);
		send_access(FUNC_READ, 1'b0, 8'h00);
	endtask

	task automatic test_strap_rows();
		for (int row = 0; row < STRAP_ROWS; row++) begin
			write_strap(5'(row));
			send_access(FUNC_SRST, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			send_access(FUNC_READ, 1'b1, 8'h00);
			send_access(FUNC_WRITE, 1'b0, 8'(REG_FAR));
			send_access(FUNC_READ, 1'b1, 8'h00);
			send_access(FUNC_WRITE, 1'b0, 8'(REG_PTR));
			send_access(FUNC_READ, 1'b1, 8'h00);
		end
	endtask

	task automatic test_random();
		int         stop_at;
		int         roll;
		int         burst;
		logic [7:0] idx;
		logic [1:0] f;
		stop_at = accesses_sent + RANDOM_ACCESSES;
		while (accesses_sent < stop_at) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) begin
				roll = $urandom_range(0, 3);
				write_strap(roll == 0 ? 5'd0 : roll == 1 ? 5'd31 : 5'($urandom_range(0, 31)));
				send_access(FUNC_SRST, 1'b0, 8'($urandom_range(0, 255)));
			end
			repeat (40) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					// select a register, then a few data-port accesses
					idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, NUM_REGS - 1));
					send_access(FUNC_WRITE, 1'b0, idx);
					burst = $urandom_range(1, 4);
					repeat (burst) begin
						f = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
						send_access(f, 1'b1, 8'($urandom_range(0, 255)));
					end
				end else if (roll < 82) begin
					send_access(FUNC_READ, 1'b0, 8'($urandom_range(0, 255)));
				end else if (roll < 90) begin
					send_access(FUNC_SRST, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end else if (roll < 95) begin
					send_access(FUNC_NONE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end else begin
					send_access(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.data  = '0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		strap_row = STRAP_DEFAULT;
		load_strap_row();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_id_sequence();
		test_register_access();
		test_strap_rows();
		test_random();

		wait_idle();
		if (mismatches == 0 && pending_decodes.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
src/scrd_pkg.sv
src/scrd_ifs.sv
src/superio_config_register_decoder.sv
bench/tb.sv
